// ----- src/bppc_pkg.sv -----
// Shared types, codes and constant tables for the board photo pixel compositor.
package bppc_pkg;

	localparam int unsigned WEIGHT_FRAC_BITS_DEF = 16;
	localparam int unsigned CFG_DATA_W = 24;
	localparam int unsigned CFG_INDEX_W = 3;

	localparam logic [1:0] CODE_NONE = 2'd0;
	localparam logic [1:0] CODE_PLAIN = 2'd1;
	localparam logic [1:0] CODE_TOP = 2'd2;
	localparam logic [1:0] CODE_BOTTOM = 2'd3;

	localparam logic [1:0] FIN_GOLD = 2'd0;
	localparam logic [1:0] FIN_TIN = 2'd1;
	localparam logic [1:0] FIN_SILVER = 2'd2;
	localparam logic [1:0] FIN_COPPER = 2'd3;

	localparam logic [CFG_INDEX_W-1:0] REG_PLATING_FINISH = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MASK_TINT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SILK_TINT = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SILK_HIGHLIGHT = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SILK_LOWLIGHT = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_ENABLE = 3'd5;

	localparam logic [CFG_DATA_W-1:0] SILK_TINT_RESET = 24'hFFFFFF;
	localparam logic [6:0] ALPHA_TRANSPARENT = 7'd127;

	localparam logic [15:0] DIV255_RECIP = 16'h8081;
	localparam int unsigned DIV255_SHIFT = 23;

	typedef struct packed {
		logic [1:0] cu;
		logic [1:0] mk;
		logic [1:0] sk;
	} layer_codes_t;

	function automatic logic [7:0] finish_base(input int unsigned fin, input int unsigned k);
		logic [7:0] v;
		case (fin)
			FIN_GOLD: v = (k == 0) ? 8'd185 : ((k == 1) ? 8'd146 : 8'd52);
			FIN_TIN: v = (k == 0) ? 8'd140 : ((k == 1) ? 8'd150 : 8'd160);
			FIN_SILVER: v = (k == 0) ? 8'd192 : ((k == 1) ? 8'd192 : 8'd185);
			default: v = (k == 0) ? 8'd184 : ((k == 1) ? 8'd115 : 8'd51);
		endcase
		return v;
	endfunction

	function automatic logic [7:0] masked_copper(input int unsigned k);
		logic [7:0] v;
		v = (k == 0) ? 8'd220 : ((k == 1) ? 8'd145 : 8'd230);
		return v;
	endfunction

endpackage

// ----- src/bppc_channel.sv -----
// Four-stage datapath for one color channel of the pixel compositor.
module bppc_channel #(
	parameter int unsigned WEIGHT_FRAC_BITS = bppc_pkg::WEIGHT_FRAC_BITS_DEF,
	parameter int unsigned CHAN = 0
) (
	input logic clk,
	input bppc_pkg::layer_codes_t codes,
	input logic inner_copper,
	input logic signed [2:0] tin_noise,
	input logic [1:0] plating_finish,
	input logic [7:0] mask_tint,
	input logic [7:0] silk_tint,
	input logic [7:0] silk_highlight,
	input logic [7:0] silk_lowlight,
	output logic [7:0] color
);
	import bppc_pkg::*;

	localparam int unsigned F = WEIGHT_FRAC_BITS;
	localparam longint unsigned ONE = longint'(1) << F;
	localparam longint unsigned W07 = (7 * ONE + 5) / 10;
	localparam longint unsigned W03 = (3 * ONE + 5) / 10;
	localparam longint unsigned W02 = (2 * ONE + 5) / 10;
	localparam longint unsigned SUB_BASE = (CHAN == 2) ? 110 : 100;
	localparam longint unsigned SUB_PLAIN = (SUB_BASE * W03 + 70 * (ONE - W03)) >> F;
	localparam longint unsigned SUB_INNER = (40 * W03 + 70 * (ONE - W03)) >> F;
	localparam logic [F-1:0] W07_F = F'(W07);
	localparam logic [F-1:0] W02_F = F'(W02);
	localparam logic [F+7:0] FULL255 = (F+8)'(255 * ONE);
	localparam logic [F+7:0] LIGHT_ADD = (F+8)'(255 * (ONE - W07));

	logic [7:0] fin_plain [4];
	logic [7:0] fin_top [4];

	for (genvar i = 0; i < 4; i++) begin : g_fin
		localparam longint unsigned BASE = finish_base(i, CHAN);
		localparam longint unsigned TOP = (BASE * W07 + 255 * (ONE - W07)) >> F;
		assign fin_plain[i] = 8'(BASE);
		assign fin_top[i] = 8'(TOP);
	end

	// Stage 1: substrate, masked copper or finish color.
	logic signed [3:0] noise2;
	logic signed [9:0] tin_sum;
	logic [7:0] c_d1;
	logic [7:0] c_s1;
	layer_codes_t codes_s1;

	assign noise2 = {tin_noise, 1'b0};
	assign tin_sum = $signed({2'b00, fin_plain[FIN_TIN]}) + 10'(noise2);

	always_comb begin
		c_d1 = inner_copper ? 8'(SUB_INNER) : 8'(SUB_PLAIN);
		if (codes.cu != CODE_NONE) begin
			if (codes.mk != CODE_NONE) begin
				c_d1 = masked_copper(CHAN);
			end else if (plating_finish == FIN_TIN) begin
				c_d1 = 8'(tin_sum);
			end else if (codes.cu == CODE_TOP) begin
				c_d1 = fin_top[plating_finish];
			end else begin
				c_d1 = fin_plain[plating_finish];
			end
		end
	end

	always_ff @(posedge clk) begin
		c_s1 <= c_d1;
		codes_s1 <= codes;
	end

	// Stage 2: copper shading.
	logic [7:0] sh_op;
	logic [F+7:0] sh_prod;
	logic [F+7:0] sh_top;
	logic [7:0] c_d2;
	logic [7:0] c_s2;
	layer_codes_t codes_s2;

	assign sh_op = (codes_s1.cu == CODE_TOP) ? 8'(8'd255 - c_s1) : c_s1;
	assign sh_prod = (F+8)'(sh_op) * (F+8)'(W07_F);
	assign sh_top = FULL255 - sh_prod;

	always_comb begin
		case (codes_s1.cu)
			CODE_TOP: c_d2 = sh_top[F+7:F];
			CODE_BOTTOM: c_d2 = sh_prod[F+7:F];
			default: c_d2 = c_s1;
		endcase
	end

	always_ff @(posedge clk) begin
		c_s2 <= c_d2;
		codes_s2 <= codes_s1;
	end

	// Stage 3: mask products.
	logic [15:0] pcm;
	logic [F+7:0] mw;
	logic [15:0] pcm_s3;
	logic [7:0] mwq_s3;
	logic [7:0] c_s3;
	layer_codes_t codes_s3;

	assign pcm = 16'(c_s2) * 16'(mask_tint);
	assign mw = (F+8)'(mask_tint) * (F+8)'(W02_F);

	always_ff @(posedge clk) begin
		pcm_s3 <= pcm;
		mwq_s3 <= mw[F+7:F];
		c_s3 <= c_s2;
		codes_s3 <= codes_s2;
	end

	// Stage 4: divide by 255 and add the tint.
	logic [31:0] q_prod;
	logic [8:0] tint_sum;
	logic [7:0] cm_s4;
	logic [7:0] c_s4;
	layer_codes_t codes_s4;

	assign q_prod = 32'(pcm_s3) * 32'(DIV255_RECIP);
	assign tint_sum = 9'(q_prod[DIV255_SHIFT+7:DIV255_SHIFT]) + 9'(mwq_s3);

	always_ff @(posedge clk) begin
		cm_s4 <= tint_sum[8] ? 8'hFF : tint_sum[7:0];
		c_s4 <= c_s3;
		codes_s4 <= codes_s3;
	end

	// Final select: mask shading or silk.
	logic [F+7:0] mix_prod;
	logic [F+7:0] mix_top;
	logic [7:0] mask_c;
	logic [8:0] silk_sum;
	logic [7:0] silk_c;

	assign mix_prod = (F+8)'(cm_s4) * (F+8)'(W07_F);
	assign mix_top = mix_prod + LIGHT_ADD;
	assign silk_sum = 9'(silk_tint) + 9'(silk_highlight);

	always_comb begin
		case (codes_s4.mk)
			CODE_TOP: mask_c = mix_top[F+7:F];
			CODE_BOTTOM: mask_c = mix_prod[F+7:F];
			default: mask_c = cm_s4;
		endcase
		case (codes_s4.sk)
			CODE_TOP: silk_c = silk_sum[8] ? 8'hFF : silk_sum[7:0];
			CODE_BOTTOM: silk_c = (silk_lowlight > silk_tint) ? 8'd0 : 8'(silk_tint - silk_lowlight);
			default: silk_c = silk_tint;
		endcase
		if (codes_s4.sk != CODE_NONE) begin
			color = silk_c;
		end else if (codes_s4.mk != CODE_NONE) begin
			color = mask_c;
		end else begin
			color = c_s4;
		end
	end

endmodule

// ----- src/board_photo_pixel_compositor_core.sv -----
// Top level of the board photo pixel compositor.
// The block turns the layer codes of one board pixel into a photo-style color.
// A request is taken at a rising edge with start high and busy low; busy is
// always low, so a new pixel may be issued in every cycle.
// Each pixel yields exactly one result on red, green, blue, transparent and
// alpha, marked by a one-cycle done strobe. The receiver cannot hold results
// off, and the pipeline never stalls.
// The datapath has five register stages: color select, copper shading, mask
// product, divide by 255 with tint add, and the output register. Throughput
// is one pixel per cycle, since busy is never raised.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_wdata. The user must write them only while no request is in flight;
// the block does not enforce this. Indexes above five are ignored.
// Reset clears the valid bits of the pipeline and sets the registers to their
// defaults (silk tint white, all others zero).
module board_photo_pixel_compositor_core #(
	parameter int unsigned WEIGHT_FRAC_BITS = bppc_pkg::WEIGHT_FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] top_copper,
	input logic [1:0] mask_code,
	input logic [1:0] silk_code,
	input logic inner_copper,
	input logic drill_hole,
	input logic outside_board,
	input logic signed [2:0] tin_noise,
	output logic done,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic transparent,
	output logic [6:0] alpha,
	input logic cfg_we,
	input logic [bppc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [bppc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import bppc_pkg::*;

	logic [1:0] plating_finish_q;
	logic [23:0] mask_tint_q;
	logic [23:0] silk_tint_q;
	logic [23:0] silk_highlight_q;
	logic [23:0] silk_lowlight_q;
	logic alpha_enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plating_finish_q <= FIN_GOLD;
			mask_tint_q <= '0;
			silk_tint_q <= SILK_TINT_RESET;
			silk_highlight_q <= '0;
			silk_lowlight_q <= '0;
			alpha_enable_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PLATING_FINISH: plating_finish_q <= cfg_wdata[1:0];
				REG_MASK_TINT: mask_tint_q <= cfg_wdata[23:0];
				REG_SILK_TINT: silk_tint_q <= cfg_wdata[23:0];
				REG_SILK_HIGHLIGHT: silk_highlight_q <= cfg_wdata[23:0];
				REG_SILK_LOWLIGHT: silk_lowlight_q <= cfg_wdata[23:0];
				REG_ALPHA_ENABLE: alpha_enable_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic accept;
	layer_codes_t codes;

	assign accept = start && !busy;
	assign codes = '{cu: top_copper, mk: mask_code, sk: silk_code};

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic transp_s1, transp_s2, transp_s3, transp_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			done <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			done <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		transp_s1 <= drill_hole || outside_board;
		transp_s2 <= transp_s1;
		transp_s3 <= transp_s2;
		transp_s4 <= transp_s3;
	end

	logic [7:0] chan_color [3];

	for (genvar k = 0; k < 3; k++) begin : g_chan
		bppc_channel #(
			.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS),
			.CHAN(k)
		) u_channel (
			.clk(clk),
			.codes(codes),
			.inner_copper(inner_copper),
			.tin_noise(tin_noise),
			.plating_finish(plating_finish_q),
			.mask_tint(mask_tint_q[23-8*k -: 8]),
			.silk_tint(silk_tint_q[23-8*k -: 8]),
			.silk_highlight(silk_highlight_q[23-8*k -: 8]),
			.silk_lowlight(silk_lowlight_q[23-8*k -: 8]),
			.color(chan_color[k])
		);
	end

	always_ff @(posedge clk) begin
		red <= transp_s4 ? 8'd0 : chan_color[0];
		green <= transp_s4 ? 8'd0 : chan_color[1];
		blue <= transp_s4 ? 8'd0 : chan_color[2];
		transparent <= transp_s4;
		alpha <= (transp_s4 && alpha_enable_q) ? ALPHA_TRANSPARENT : 7'd0;
	end

endmodule

// ----- src/bppc_checker.sv -----
// Port-level checks for the pixel compositor, bound to its top level.
module bppc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic transparent,
	input logic [6:0] alpha
);
	import bppc_pkg::*;

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 5))
		else $error("Result without a matching request.");

	a_no_lost: assert property (@(posedge clk) disable iff (!arst_n)
		($past(start && !busy, 5) && $past(arst_n, 1) && $past(arst_n, 2) && $past(arst_n, 3)
			&& $past(arst_n, 4) && $past(arst_n, 5)) |-> done)
		else $error("Request produced no result.");

	a_transp_black: assert property (@(posedge clk) disable iff (!arst_n)
		(done && transparent) |-> (red == 8'd0 && green == 8'd0 && blue == 8'd0))
		else $error("Transparent pixel with nonzero color.");

	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(done && alpha != 7'd0) |-> (transparent && alpha == ALPHA_TRANSPARENT))
		else $error("Alpha set on an opaque pixel or with a wrong value.");

endmodule

bind board_photo_pixel_compositor_core bppc_checker u_bppc_checker (.*);
